// ===== src/rpjp_pkg.sv =====
`default_nettype none
package rpjp_pkg;

  localparam int MAX_JOBS = 4096;
  localparam int ID_W     = $clog2(MAX_JOBS);
  localparam int SLOT_W   = ID_W;
  localparam int CNT_W    = ID_W + 1;
  localparam int POOL_AW  = SLOT_W + 2;
  localparam int LOC_W    = SLOT_W + 2;
  localparam int PCT_W    = 7;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // rate * size / 100 by reciprocal multiplication
  // ceil(2**26 / 100) gives the exact quotient for every product below 2**20
  localparam int PROD_W    = PCT_W + CNT_W;
  localparam int MUL_W     = 2 * PROD_W - 1;
  localparam int PCT_SHIFT = 26;
  localparam logic [PROD_W-1:0] PCT_RECIP = PROD_W'(671089);

  localparam logic [1:0] POOL_WORK  = 2'd0;
  localparam logic [1:0] POOL_OVER  = 2'd1;
  localparam logic [1:0] POOL_UNINT = 2'd2;
  localparam logic [1:0] PLACE_IGN  = 2'd3;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;

  localparam logic [1:0] CFG_ADOPT_RATE = 2'd0;
  localparam logic [1:0] CFG_EXPL_LIMIT = 2'd1;
  localparam logic [1:0] CFG_WSET_LIMIT = 2'd2;
  localparam logic [1:0] CFG_RNG_SEED   = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] job_id;
    logic            is_interesting;
  } in_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  chosen_job;
    logic             no_job;
    logic [1:0]       placed_pool;
    logic [CNT_W-1:0] working_count;
    logic [CNT_W-1:0] overflow_count;
    logic [CNT_W-1:0] uninterested_count;
  } out_rsp_t;

  typedef struct packed {
    logic               pool_we;
    logic [POOL_AW-1:0] pool_waddr;
    logic [ID_W-1:0]    pool_wdata;
    logic               pool_re;
    logic [POOL_AW-1:0] pool_raddr;
    logic               loc_we;
    logic [ID_W-1:0]    loc_waddr;
    logic [LOC_W-1:0]   loc_wdata;
    logic               loc_re;
    logic [ID_W-1:0]    loc_raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== src/random_pick_job_pools_core.sv =====
`default_nettype none
// channel   | ports                         | handshake
// request   | in_req                        | start high, busy low
// result    | out_rsp                       | out_valid, one cycle
// config    | cfg_index, cfg_wdata          | cfg_we, immediate
//
// after reset every location table entry is cleared with busy high
// a remove of a present job may be followed by a refill from the overflow pool
// a random pick runs through the one-bit-per-cycle remainder unit
// a select may first adopt uninterested jobs, one job at a time
// the location table and pool memory give one read and one write per cycle
// results cannot be stalled; out_valid pulses once per request
module random_pick_job_pools_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire rpjp_pkg::in_req_t  in_req,
  output logic                    out_valid,
  output rpjp_pkg::out_rsp_t      out_rsp,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import rpjp_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR      = 14'b00000000000001,
    S_IDLE       = 14'b00000000000010,
    S_ADD_LOC    = 14'b00000000000100,
    S_RAND       = 14'b00000000001000,
    S_DIV        = 14'b00000000010000,
    S_PICK       = 14'b00000000100000,
    S_RM_ISSUE   = 14'b00000001000000,
    S_RM_LOC     = 14'b00000010000000,
    S_RM_LAST    = 14'b00000100000000,
    S_RM_CLR     = 14'b00001000000000,
    S_RM_END     = 14'b00010000000000,
    S_ADOPT_NEXT = 14'b00100000000000,
    S_DONE       = 14'b01000000000000,
    S_ADOPT_CNT  = 14'b10000000000000
  } state_t;

  typedef enum logic [3:0] {
    CTX_REMOVE = 4'b0001,
    CTX_REFILL = 4'b0010,
    CTX_ADOPT  = 4'b0100,
    CTX_SELECT = 4'b1000
  } ctx_t;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;

  logic [PCT_W-1:0] rate_r;
  logic [CNT_W-1:0] expl_r, wset_r;
  logic [31:0]      lfsr_r, lfsr_nxt, lfsr_step;

  logic [CNT_W-1:0] wsize_r, wsize_nxt, osize_r, osize_nxt, usize_r, usize_nxt;
  logic [ID_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0] adopt_cnt_r, adopt_cnt_nxt;
  logic [PROD_W-1:0] adopt_prod_r, adopt_prod_nxt;
  logic             int_r, int_nxt;
  logic [ID_W-1:0]  cur_id_r, cur_id_nxt;
  logic [1:0]       psel_r, psel_nxt;
  logic [LOC_W-1:0] loc_r, loc_nxt;
  logic [ID_W-1:0]  chosen_r, chosen_nxt;
  logic             nojob_r, nojob_nxt;
  logic [1:0]       placed_r, placed_nxt;
  logic             out_valid_r;
  out_rsp_t         out_rsp_r;

  mem_req_t         mreq;
  logic [ID_W-1:0]  pool_rdata;
  logic [LOC_W-1:0] loc_rdata;

  logic             div_start, div_done;
  logic [31:0]      div_num;
  logic [CNT_W-1:0] div_den, div_rem;

  logic             ins_en;
  logic [1:0]       ins_pool;
  logic [CNT_W-1:0] psize, rsize;
  logic [1:0]       rpool, lpool;
  logic [1:0]       plc_pool;
  logic             plc_step;
  logic [MUL_W-1:0] adopt_mul;
  logic [CNT_W-1:0] adopt_quo;

  rpjp_store u_store (
    .clk        (clk),
    .req        (mreq),
    .pool_rdata (pool_rdata),
    .loc_rdata  (loc_rdata)
  );

  rpjp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign lfsr_step = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? LFSR_TAPS : 32'd0);

  always_comb begin
    case (psel_r)
      POOL_WORK: psize = wsize_r;
      POOL_OVER: psize = osize_r;
      default:   psize = usize_r;
    endcase
  end

  // pool of the location word held in the table (tag is pool plus one)
  assign rpool = loc_rdata[LOC_W-1:LOC_W-2] - 2'd1;
  assign lpool = loc_r[LOC_W-1:LOC_W-2] - 2'd1;
  always_comb begin
    case (rpool)
      POOL_WORK: rsize = wsize_r;
      POOL_OVER: rsize = osize_r;
      default:   rsize = usize_r;
    endcase
  end

  // placement of an interesting job
  always_comb begin
    plc_pool = POOL_OVER;
    plc_step = 1'b0;
    if (wsize_r < expl_r) begin
      plc_pool = POOL_WORK;
    end else if (wsize_r < wset_r) begin
      plc_step = 1'b1;
      if (lfsr_step[0]) begin
        plc_pool = POOL_WORK;
      end
    end
  end

  // adoption count: rate * size / 100
  assign adopt_mul = MUL_W'(adopt_prod_r) * MUL_W'(PCT_RECIP);
  assign adopt_quo = adopt_mul[PCT_SHIFT +: CNT_W];

  always_comb begin
    state_nxt      = state_r;
    ctx_nxt        = ctx_r;
    lfsr_nxt       = lfsr_r;
    wsize_nxt      = wsize_r;
    osize_nxt      = osize_r;
    usize_nxt      = usize_r;
    clr_cnt_nxt    = clr_cnt_r;
    adopt_cnt_nxt  = adopt_cnt_r;
    adopt_prod_nxt = adopt_prod_r;
    int_nxt        = int_r;
    cur_id_nxt     = cur_id_r;
    psel_nxt       = psel_r;
    loc_nxt        = loc_r;
    chosen_nxt     = chosen_r;
    nojob_nxt      = nojob_r;
    placed_nxt     = placed_r;
    mreq           = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    ins_en         = 1'b0;
    ins_pool       = POOL_WORK;

    case (state_r)
      S_CLEAR: begin
        mreq.loc_we    = 1'b1;
        mreq.loc_waddr = clr_cnt_r;
        mreq.loc_wdata = '0;
        clr_cnt_nxt    = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          int_nxt    = in_req.is_interesting;
          cur_id_nxt = in_req.job_id;
          chosen_nxt = '0;
          nojob_nxt  = 1'b0;
          placed_nxt = PLACE_IGN;
          case (in_req.op)
            OP_ADD: begin
              mreq.loc_re    = 1'b1;
              mreq.loc_raddr = in_req.job_id;
              state_nxt      = S_ADD_LOC;
            end
            OP_REMOVE: begin
              ctx_nxt   = CTX_REMOVE;
              state_nxt = S_RM_ISSUE;
            end
            OP_SELECT: begin
              if (wsize_r == '0 && usize_r != '0) begin
                adopt_prod_nxt = PROD_W'(rate_r) * PROD_W'(usize_r);
                ctx_nxt        = CTX_ADOPT;
                state_nxt      = S_ADOPT_CNT;
              end else if (wsize_r == '0) begin
                nojob_nxt = 1'b1;
                state_nxt = S_DONE;
              end else begin
                ctx_nxt   = CTX_SELECT;
                psel_nxt  = POOL_WORK;
                state_nxt = S_RAND;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ADOPT_CNT: begin
        // clamped to 1..size
        if (adopt_quo == '0) begin
          adopt_cnt_nxt = CNT_W'(1);
        end else if (adopt_quo > usize_r) begin
          adopt_cnt_nxt = usize_r;
        end else begin
          adopt_cnt_nxt = adopt_quo;
        end
        state_nxt = S_ADOPT_NEXT;
      end
      S_ADD_LOC: begin
        if (loc_rdata != '0) begin
          state_nxt = S_DONE;
        end else begin
          ins_en = 1'b1;
          if (int_r) begin
            ins_pool = plc_pool;
            if (plc_step) begin
              lfsr_nxt = lfsr_step;
            end
          end else begin
            ins_pool = POOL_UNINT;
          end
          placed_nxt = ins_pool;
          state_nxt  = S_DONE;
        end
      end
      S_RAND: begin
        lfsr_nxt  = lfsr_step;
        div_num   = lfsr_step;
        div_den   = psize;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          mreq.pool_re    = 1'b1;
          mreq.pool_raddr = {psel_r, div_rem[SLOT_W-1:0]};
          state_nxt       = S_PICK;
        end
      end
      S_PICK: begin
        if (ctx_r == CTX_SELECT) begin
          chosen_nxt = pool_rdata;
          state_nxt  = S_DONE;
        end else begin
          cur_id_nxt = pool_rdata;
          state_nxt  = S_RM_ISSUE;
        end
      end
      S_RM_ISSUE: begin
        mreq.loc_re    = 1'b1;
        mreq.loc_raddr = cur_id_r;
        state_nxt      = S_RM_LOC;
      end
      S_RM_LOC: begin
        loc_nxt = loc_rdata;
        if (loc_rdata[LOC_W-1:LOC_W-2] == 2'd0) begin
          state_nxt = S_RM_END;
        end else if (rsize == '0 || CNT_W'(loc_rdata[SLOT_W-1:0]) >= rsize) begin
          mreq.loc_we    = 1'b1;
          mreq.loc_waddr = cur_id_r;
          mreq.loc_wdata = '0;
          state_nxt      = S_RM_END;
        end else begin
          mreq.pool_re    = 1'b1;
          mreq.pool_raddr = {rpool, SLOT_W'(rsize - 1'b1)};
          state_nxt       = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        // last entry fills the freed slot
        mreq.pool_we    = 1'b1;
        mreq.pool_waddr = {lpool, loc_r[SLOT_W-1:0]};
        mreq.pool_wdata = pool_rdata;
        mreq.loc_we     = 1'b1;
        mreq.loc_waddr  = pool_rdata;
        mreq.loc_wdata  = loc_r;
        case (lpool)
          POOL_WORK: wsize_nxt = wsize_r - 1'b1;
          POOL_OVER: osize_nxt = osize_r - 1'b1;
          default:   usize_nxt = usize_r - 1'b1;
        endcase
        state_nxt = S_RM_CLR;
      end
      S_RM_CLR: begin
        mreq.loc_we    = 1'b1;
        mreq.loc_waddr = cur_id_r;
        mreq.loc_wdata = '0;
        state_nxt      = S_RM_END;
      end
      S_RM_END: begin
        case (ctx_r)
          CTX_REMOVE: begin
            if (wsize_r < expl_r && osize_r != '0) begin
              ctx_nxt   = CTX_REFILL;
              psel_nxt  = POOL_OVER;
              state_nxt = S_RAND;
            end else begin
              state_nxt = S_DONE;
            end
          end
          CTX_REFILL: begin
            ins_en    = 1'b1;
            ins_pool  = POOL_WORK;
            state_nxt = S_DONE;
          end
          default: begin
            ins_en   = 1'b1;
            ins_pool = plc_pool;
            if (plc_step) begin
              lfsr_nxt = lfsr_step;
            end
            state_nxt = S_ADOPT_NEXT;
          end
        endcase
      end
      S_ADOPT_NEXT: begin
        if (adopt_cnt_r == '0 || usize_r == '0) begin
          if (wsize_r == '0) begin
            nojob_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            ctx_nxt   = CTX_SELECT;
            psel_nxt  = POOL_WORK;
            state_nxt = S_RAND;
          end
        end else begin
          adopt_cnt_nxt = adopt_cnt_r - 1'b1;
          psel_nxt      = POOL_UNINT;
          state_nxt     = S_RAND;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (ins_en) begin
      mreq.pool_we   = 1'b1;
      mreq.loc_we    = 1'b1;
      mreq.loc_waddr = cur_id_r;
      mreq.pool_wdata = cur_id_r;
      case (ins_pool)
        POOL_WORK: begin
          mreq.pool_waddr = {POOL_WORK, wsize_r[SLOT_W-1:0]};
          mreq.loc_wdata  = {POOL_WORK + 2'd1, wsize_r[SLOT_W-1:0]};
          wsize_nxt       = wsize_r + 1'b1;
        end
        POOL_OVER: begin
          mreq.pool_waddr = {POOL_OVER, osize_r[SLOT_W-1:0]};
          mreq.loc_wdata  = {POOL_OVER + 2'd1, osize_r[SLOT_W-1:0]};
          osize_nxt       = osize_r + 1'b1;
        end
        default: begin
          mreq.pool_waddr = {POOL_UNINT, usize_r[SLOT_W-1:0]};
          mreq.loc_wdata  = {POOL_UNINT + 2'd1, usize_r[SLOT_W-1:0]};
          usize_nxt       = usize_r + 1'b1;
        end
      endcase
    end

    // seed write reloads the generator
    if (cfg_we && cfg_index == CFG_RNG_SEED) begin
      lfsr_nxt = (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ctx_r       <= CTX_REMOVE;
      clr_cnt_r   <= '0;
      wsize_r     <= '0;
      osize_r     <= '0;
      usize_r     <= '0;
      lfsr_r      <= 32'd1;
      rate_r      <= PCT_W'(10);
      expl_r      <= CNT_W'(500);
      wset_r      <= CNT_W'(1000);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wsize_r     <= wsize_nxt;
      osize_r     <= osize_nxt;
      usize_r     <= usize_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADOPT_RATE: rate_r <= cfg_wdata[PCT_W-1:0];
          CFG_EXPL_LIMIT: expl_r <= cfg_wdata[CNT_W-1:0];
          CFG_WSET_LIMIT: wset_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    adopt_cnt_r  <= adopt_cnt_nxt;
    adopt_prod_r <= adopt_prod_nxt;
    int_r        <= int_nxt;
    cur_id_r     <= cur_id_nxt;
    psel_r       <= psel_nxt;
    loc_r        <= loc_nxt;
    chosen_r     <= chosen_nxt;
    nojob_r      <= nojob_nxt;
    placed_r     <= placed_nxt;
    if (state_r == S_DONE) begin
      out_rsp_r.chosen_job         <= chosen_r;
      out_rsp_r.no_job             <= nojob_r;
      out_rsp_r.placed_pool        <= placed_r;
      out_rsp_r.working_count      <= wsize_r;
      out_rsp_r.overflow_count     <= osize_r;
      out_rsp_r.uninterested_count <= usize_r;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef ASSERT_OFF
  a_req_takes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished request");

  a_nojob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.no_job) |-> (out_rsp.chosen_job == '0))
    else $error("no_job with a chosen job");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wsize_r) + 32'(osize_r) + 32'(usize_r)) <= MAX_JOBS)
    else $error("pools hold more jobs than ids exist");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");
`endif

endmodule
`default_nettype wire

// ===== src/rpjp_div.sv =====
`default_nettype none
module rpjp_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [31:0]              num,
  input  wire logic [rpjp_pkg::CNT_W-1:0] den,
  output logic                          done,
  output logic [rpjp_pkg::CNT_W-1:0]    rem
);
  import rpjp_pkg::*;

  logic [31:0]      num_r, num_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] den_r, den_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[31]};
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, den_r});
        num_nxt = {num_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        num_nxt = {num_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== src/rpjp_store.sv =====
`default_nettype none
module rpjp_store (
  input  wire logic                     clk,
  input  wire rpjp_pkg::mem_req_t       req,
  output logic [rpjp_pkg::ID_W-1:0]     pool_rdata,
  output logic [rpjp_pkg::LOC_W-1:0]    loc_rdata
);
  import rpjp_pkg::*;

  localparam int POOL_DEPTH = 3 * MAX_JOBS;

  // three id pools share one memory, addressed by {pool, slot}
  logic [ID_W-1:0]  pool_mem [POOL_DEPTH];
  logic [LOC_W-1:0] loc_mem  [MAX_JOBS];

  always_ff @(posedge clk) begin
    if (req.pool_we) begin
      pool_mem[req.pool_waddr] <= req.pool_wdata;
    end
    if (req.pool_re) begin
      pool_rdata <= pool_mem[req.pool_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.loc_we) begin
      loc_mem[req.loc_waddr] <= req.loc_wdata;
    end
    if (req.loc_re) begin
      loc_rdata <= loc_mem[req.loc_raddr];
    end
  end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import rpjp_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int QUIET_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_req_t in_req = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic busy;
  logic out_valid;
  out_rsp_t out_rsp;

  random_pick_job_pools_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow of the job pools
  logic [ID_W-1:0] pool_ids [3][MAX_JOBS];
  int unsigned pool_cnt [3];
  int unsigned job_loc [MAX_JOBS];
  int unsigned rate_q, expl_q, wset_q;
  logic [31:0] lfsr_q;

  in_req_t req_q [$];
  out_rsp_t rsp_q [$];
  int err_cnt = 0;
  int n_req = 0, n_rsp = 0, n_nojob = 0, n_over = 0;
  int quiet = 0;

  function automatic void req_add(in_req_t r);
    req_q.insert(req_q.size(), r);
  endfunction

  function automatic logic [31:0] lfsr_advance();
    logic out_bit;
    out_bit = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (out_bit) lfsr_q = lfsr_q ^ LFSR_TAPS;
    return lfsr_q;
  endfunction

  function automatic void pool_put(int p, logic [ID_W-1:0] id);
    if (pool_cnt[p] >= MAX_JOBS) return;
    pool_ids[p][pool_cnt[p]] = id;
    job_loc[id] = ((p + 1) << 16) | pool_cnt[p];
    pool_cnt[p]++;
  endfunction

  function automatic void pool_drop(logic [ID_W-1:0] id);
    int unsigned l, p, slot;
    logic [ID_W-1:0] last;
    l = job_loc[id];
    if (l == 0) return;
    p = (l >> 16) - 1;
    slot = l & 32'hFFFF;
    if (pool_cnt[p] == 0 || slot >= pool_cnt[p]) begin
      job_loc[id] = 0;
      return;
    end
    last = pool_ids[p][pool_cnt[p] - 1];
    pool_ids[p][slot] = last;
    job_loc[last] = l;
    pool_cnt[p]--;
    job_loc[id] = 0;
  endfunction

  function automatic logic [ID_W-1:0] pool_pick(int p);
    logic [31:0] r;
    r = lfsr_advance();
    return pool_ids[p][r % pool_cnt[p]];
  endfunction

  function automatic logic [1:0] place_wanted(logic [ID_W-1:0] id);
    logic [1:0] p;
    p = POOL_OVER;
    if (pool_cnt[POOL_WORK] < expl_q) begin
      p = POOL_WORK;
    end else if (pool_cnt[POOL_WORK] < wset_q) begin
      if (lfsr_advance() & 1) p = POOL_WORK;
    end
    pool_put(p, id);
    return p;
  endfunction

  function automatic out_rsp_t pool_step(in_req_t r);
    out_rsp_t o;
    int unsigned n;
    logic [ID_W-1:0] id;
    o = '0;
    o.placed_pool = PLACE_IGN;
    case (r.op)
      OP_ADD: begin
        if (job_loc[r.job_id] == 0) begin
          if (r.is_interesting) begin
            o.placed_pool = place_wanted(r.job_id);
          end else begin
            pool_put(POOL_UNINT, r.job_id);
            o.placed_pool = POOL_UNINT;
          end
        end
      end
      OP_REMOVE: begin
        pool_drop(r.job_id);
        if (pool_cnt[POOL_WORK] < expl_q && pool_cnt[POOL_OVER] > 0) begin
          id = pool_pick(POOL_OVER);
          pool_drop(id);
          pool_put(POOL_WORK, id);
        end
      end
      OP_SELECT: begin
        if (pool_cnt[POOL_WORK] == 0 && pool_cnt[POOL_UNINT] > 0) begin
          // adopt a share of the uninterested jobs
          n = rate_q * pool_cnt[POOL_UNINT] / 100;
          if (n == 0) n = 1;
          if (n > pool_cnt[POOL_UNINT]) n = pool_cnt[POOL_UNINT];
          for (int i = 0; i < n; i++) begin
            id = pool_pick(POOL_UNINT);
            pool_drop(id);
            void'(place_wanted(id));
          end
        end
        if (pool_cnt[POOL_WORK] == 0) o.no_job = 1'b1;
        else o.chosen_job = pool_pick(POOL_WORK);
      end
      default: ;
    endcase
    o.working_count = CNT_W'(pool_cnt[POOL_WORK]);
    o.overflow_count = CNT_W'(pool_cnt[POOL_OVER]);
    o.uninterested_count = CNT_W'(pool_cnt[POOL_UNINT]);
    return o;
  endfunction

  task automatic report(string what, int exp_v, int got_v);
    err_cnt++;
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endtask

  // driver: bursts with random gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin : drv
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rsp_q.insert(rsp_q.size(), pool_step(in_req));
        void'(req_q.pop_front());
        n_req++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
      go = 1'b0;
      if (gap_left > 0 && !(start && busy)) gap_left--;
      else if (req_q.size() > 0) go = 1'b1;
      if (start && busy) go = 1'b1;
      start <= go;
      if (go) in_req <= req_q[0];
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin : mon
    out_rsp_t e;
    if (rst_n) begin
      quiet++;
      if (start && !busy) quiet = 0;
      if (out_valid) begin
        quiet = 0;
        n_rsp++;
        if (rsp_q.size() == 0) begin
          report("pending requests", 0, 1);
        end else begin
          e = rsp_q.pop_front();
          if (e.no_job) n_nojob++;
          if (e.placed_pool == POOL_OVER) n_over++;
          if (out_rsp.chosen_job !== e.chosen_job)
            report("chosen_job", e.chosen_job, out_rsp.chosen_job);
          if (out_rsp.no_job !== e.no_job) report("no_job", e.no_job, out_rsp.no_job);
          if (out_rsp.placed_pool !== e.placed_pool)
            report("placed_pool", e.placed_pool, out_rsp.placed_pool);
          if (out_rsp.working_count !== e.working_count)
            report("working_count", e.working_count, out_rsp.working_count);
          if (out_rsp.overflow_count !== e.overflow_count)
            report("overflow_count", e.overflow_count, out_rsp.overflow_count);
          if (out_rsp.uninterested_count !== e.uninterested_count)
            report("uninterested_count", e.uninterested_count, out_rsp.uninterested_count);
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic in_req_t mk_req(logic [1:0] op, int id, bit interesting);
    in_req_t r;
    r.op = op;
    r.job_id = ID_W'(id);
    r.is_interesting = interesting;
    return r;
  endfunction

  function automatic in_req_t rand_req(int id_max);
    int k;
    int id;
    logic [1:0] op;
    k = $urandom_range(0, 99);
    op = (k < 40) ? OP_ADD : (k < 65) ? OP_REMOVE : (k < 95) ? OP_SELECT : OP_NOP;
    id = ($urandom_range(0, 99) < 85) ? $urandom_range(0, id_max) : $urandom_range(0, 4095);
    return mk_req(op, id, $urandom_range(0, 9) < 7);
  endfunction

  task automatic drain();
    while (req_q.size() != 0 || rsp_q.size() != 0 || start || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_all(int unsigned rate, int unsigned expl, int unsigned wset,
                         logic [31:0] seed);
    logic [31:0] v [4];
    v[CFG_ADOPT_RATE] = rate;
    v[CFG_EXPL_LIMIT] = expl;
    v[CFG_WSET_LIMIT] = wset;
    v[CFG_RNG_SEED] = seed;
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_q = rate & 32'h7F;
    expl_q = expl & 32'h1FFF;
    wset_q = wset & 32'h1FFF;
    lfsr_q = (seed != 0) ? seed : 32'd1;
  endtask

  initial begin
    int unsigned ph_rate [6] = '{50, 100, 0, 100, 37, 10};
    int unsigned ph_expl [6] = '{4, 1, 4096, 0, 2, 8};
    int unsigned ph_wset [6] = '{8, 1, 4096, 0, 8191, 16};
    logic [31:0] ph_seed [6];
    ph_seed = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom, $urandom, $urandom};
    rate_q = 10;
    expl_q = 500;
    wset_q = 1000;
    lfsr_q = 32'd1;
    foreach (pool_cnt[i]) pool_cnt[i] = 0;
    foreach (job_loc[i]) job_loc[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests under reset settings
    req_add(mk_req(OP_SELECT, 0, 0));      // every pool empty
    req_add(mk_req(OP_ADD, 0, 1));
    req_add(mk_req(OP_ADD, 4095, 1));
    req_add(mk_req(OP_ADD, 4095, 0));      // duplicate
    req_add(mk_req(OP_ADD, 2730, 0));
    req_add(mk_req(OP_ADD, 1365, 0));
    req_add(mk_req(OP_SELECT, 0, 0));
    req_add(mk_req(OP_NOP, 4095, 1));
    req_add(mk_req(OP_REMOVE, 77, 0));     // absent job
    req_add(mk_req(OP_REMOVE, 0, 0));
    req_add(mk_req(OP_REMOVE, 4095, 0));
    req_add(mk_req(OP_SELECT, 0, 0));      // adoption from uninterested
    req_add(mk_req(OP_SELECT, 0, 0));
    req_add(mk_req(OP_ADD, 2730, 1));      // duplicate after adoption
    req_add(mk_req(OP_REMOVE, 2730, 0));
    req_add(mk_req(OP_REMOVE, 1365, 0));
    req_add(mk_req(OP_SELECT, 0, 0));
    req_add(mk_req(OP_SELECT, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_all(ph_rate[ph], ph_expl[ph], ph_wset[ph], ph_seed[ph]);
      for (int i = 0; i < 215; i++) req_add(rand_req(ph == 2 ? 15 : 47));
      // sender waits here for every result before the next settings
      drain();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d requests over 7 settings, %0d results", n_req, n_rsp);
    $display("overflow placements %0d, empty selects %0d", n_over, n_nojob);
    if (err_cnt == 0 && rsp_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rpjp_pkg.sv
src/rpjp_div.sv
src/rpjp_store.sv
src/random_pick_job_pools_core.sv
dv/testbench.sv
